>>> sv/tbp_pkg.sv
package tbp_pkg;

    localparam int LOCAL_INDEX_BITS  = 12;
    localparam int GLOBAL_INDEX_BITS = 12;
    localparam int HISTORY_BITS      = 12;

    localparam int LOCAL_DEPTH  = 1 << LOCAL_INDEX_BITS;
    localparam int GLOBAL_DEPTH = 1 << GLOBAL_INDEX_BITS;
    localparam int CLR_BITS     = (LOCAL_INDEX_BITS > GLOBAL_INDEX_BITS) ?
                                  LOCAL_INDEX_BITS : GLOBAL_INDEX_BITS;

    localparam int PC_BITS      = 32;
    localparam int CTR_BITS     = 3;
    localparam int S_TDATA_BITS = 40;
    localparam int M_TDATA_BITS = 8;

    // register indexes
    localparam logic CFG_LOCAL_MODE  = 1'b0;
    localparam logic CFG_GLOBAL_MODE = 1'b1;

    localparam logic [CTR_BITS-1:0] CTR_ZERO      = 3'b000;
    localparam logic [CTR_BITS-1:0] CTR_MAX_TWO   = 3'b011;
    localparam logic [CTR_BITS-1:0] CTR_MID_THREE = 3'b100;
    localparam logic [CTR_BITS-1:0] CTR_MAX_THREE = 3'b111;
    localparam logic [CTR_BITS-1:0] CTR_MID_TWO   = 3'd2;
    localparam logic [1:0]          CHOOSER_RESET = 2'd2;

    typedef struct packed {
        logic                accept;
        logic                update;
        logic                clear_we;
        logic                clear_local;
        logic                clear_global;
        logic [CLR_BITS-1:0] clear_addr;
        logic                mode_we_local;
        logic                mode_we_global;
    } tbp_cmd_t;

    typedef struct packed {
        logic out_blocked;
    } tbp_status_t;

    function automatic logic [CTR_BITS-1:0] midpoint(input logic mode);
        return mode ? CTR_MID_THREE : CTR_MID_TWO;
    endfunction

    function automatic logic counter_taken(input logic [CTR_BITS-1:0] v, input logic mode);
        return mode ? (v > 3'd3) : (v > 3'd1);
    endfunction

    function automatic logic [CTR_BITS-1:0] counter_next(input logic [CTR_BITS-1:0] v,
                                                         input logic mode,
                                                         input logic t);
        logic [CTR_BITS-1:0] top;
        logic [CTR_BITS-1:0] r;
        top = mode ? CTR_MAX_THREE : CTR_MAX_TWO;
        // hysteresis jumps across the midpoint
        if (mode && v == 3'd3 && t)
            r = 3'd6;
        else if (mode && v == CTR_MID_THREE && !t)
            r = CTR_ZERO;
        else if (!mode && v == 3'd1 && t)
            r = CTR_MAX_TWO;
        else if (!mode && v == CTR_MID_TWO && !t)
            r = CTR_ZERO;
        else if (t)
            r = (v < top) ? v + 3'd1 : top;
        else
            r = (v > CTR_ZERO) ? v - 3'd1 : CTR_ZERO;
        return r;
    endfunction

    function automatic logic [1:0] chooser_next(input logic [1:0] c,
                                                input logic lok,
                                                input logic gok);
        logic [1:0] r;
        r = c;
        if (!lok && gok)
            r = (c == 2'd1) ? 2'd3 : ((c < 2'd3) ? c + 2'd1 : 2'd3);
        else if (lok && !gok)
            r = (c == 2'd2) ? 2'd0 : ((c > 2'd0) ? c - 2'd1 : 2'd0);
        return r;
    endfunction

endpackage

>>> sv/tbp_ctrl.sv
module tbp_ctrl
    import tbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  tbp_status_t status,
    output tbp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE
    } state_t;

    state_t              state_reg, state_next;
    logic [CLR_BITS-1:0] clr_cnt_reg, clr_cnt_next;
    logic                clr_local_reg, clr_local_next;
    logic                clr_global_reg, clr_global_next;
    logic                s_tready_reg;

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_local_next  = clr_local_reg;
        clr_global_next = clr_global_reg;

        cmd                = '0;
        cmd.clear_addr     = clr_cnt_reg;
        cmd.clear_local    = clr_local_reg;
        cmd.clear_global   = clr_global_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_we = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1)
                begin
                    clr_local_next  = 1'b0;
                    clr_global_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid && s_tready_reg)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (!status.out_blocked)
                begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a mode write restarts the refill sweep for its table
        if (cfg_we)
        begin
            cmd.mode_we_local  = (cfg_index == CFG_LOCAL_MODE);
            cmd.mode_we_global = (cfg_index == CFG_GLOBAL_MODE);
            clr_local_next     = (state_next == ST_CLEAR && clr_local_next) ||
                                 (cfg_index == CFG_LOCAL_MODE);
            clr_global_next    = (state_next == ST_CLEAR && clr_global_next) ||
                                 (cfg_index == CFG_GLOBAL_MODE);
            clr_cnt_next       = '0;
            state_next         = ST_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            clr_local_reg  <= 1'b1;
            clr_global_reg <= 1'b1;
            s_tready_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            clr_local_reg  <= clr_local_next;
            clr_global_reg <= clr_global_next;
            s_tready_reg   <= (state_next == ST_IDLE);
        end
    end

    assign s_tready = s_tready_reg;

endmodule

>>> sv/tbp_datapath.sv
module tbp_datapath
    import tbp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [S_TDATA_BITS-1:0] s_tdata,
    input  logic                    cfg_wdata,
    input  tbp_cmd_t                cmd,
    output tbp_status_t             status,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_BITS-1:0] m_tdata
);

    logic [CTR_BITS-1:0] local_mem  [LOCAL_DEPTH];
    logic [CTR_BITS-1:0] global_mem [GLOBAL_DEPTH];

    logic                         local_mode_reg;
    logic                         global_mode_reg;
    logic [HISTORY_BITS-1:0]      history_reg, history_next;
    logic [1:0]                   chooser_reg, chooser_next_v;
    logic [LOCAL_INDEX_BITS-1:0]  li_reg;
    logic [GLOBAL_INDEX_BITS-1:0] gi_reg;
    logic                         taken_reg;
    logic [CTR_BITS-1:0]          lrd_reg, grd_reg;
    logic                         m_tvalid_reg;
    logic [M_TDATA_BITS-1:0]      m_tdata_reg;

    logic [PC_BITS-1:0]           in_pc;
    logic                         in_taken;
    logic [PC_BITS-1:0]           hist_ext;
    logic [PC_BITS-1:0]           gshare_hash;
    logic [LOCAL_INDEX_BITS-1:0]  in_li;
    logic [GLOBAL_INDEX_BITS-1:0] in_gi;

    logic                         lg, gg, cg, pred;
    logic                         local_we, global_we;
    logic [LOCAL_INDEX_BITS-1:0]  local_waddr;
    logic [GLOBAL_INDEX_BITS-1:0] global_waddr;
    logic [CTR_BITS-1:0]          local_wdata, global_wdata;

    assign in_pc       = s_tdata[PC_BITS-1:0];
    assign in_taken    = s_tdata[PC_BITS];
    assign hist_ext    = PC_BITS'(history_reg);
    assign gshare_hash = in_pc ^ hist_ext;
    assign in_li       = in_pc[LOCAL_INDEX_BITS-1:0];
    assign in_gi       = gshare_hash[GLOBAL_INDEX_BITS-1:0];

    assign lg   = counter_taken(lrd_reg, local_mode_reg);
    assign gg   = counter_taken(grd_reg, global_mode_reg);
    assign cg   = chooser_reg[1];
    assign pred = cg ? gg : lg;

    assign chooser_next_v = chooser_next(chooser_reg, lg == taken_reg, gg == taken_reg);
    assign history_next   = HISTORY_BITS'({history_reg, taken_reg});

    // single write port per table, shared by the refill sweep and the update
    always_comb
    begin
        local_we     = cmd.update || (cmd.clear_we && cmd.clear_local);
        global_we    = cmd.update || (cmd.clear_we && cmd.clear_global);
        local_waddr  = cmd.clear_we ? cmd.clear_addr[LOCAL_INDEX_BITS-1:0] : li_reg;
        global_waddr = cmd.clear_we ? cmd.clear_addr[GLOBAL_INDEX_BITS-1:0] : gi_reg;
        local_wdata  = cmd.clear_we ? midpoint(local_mode_reg) :
                       counter_next(lrd_reg, local_mode_reg, taken_reg);
        global_wdata = cmd.clear_we ? midpoint(global_mode_reg) :
                       counter_next(grd_reg, global_mode_reg, taken_reg);
    end

    always_ff @(posedge clk)
    begin
        if (local_we)
            local_mem[local_waddr] <= local_wdata;
        if (cmd.accept)
            lrd_reg <= local_mem[in_li];
    end

    always_ff @(posedge clk)
    begin
        if (global_we)
            global_mem[global_waddr] <= global_wdata;
        if (cmd.accept)
            grd_reg <= global_mem[in_gi];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            li_reg    <= in_li;
            gi_reg    <= in_gi;
            taken_reg <= in_taken;
        end
        if (cmd.update)
            m_tdata_reg <= {3'b000, pred != taken_reg, cg, gg, lg, pred};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_mode_reg  <= 1'b0;
            global_mode_reg <= 1'b0;
            history_reg     <= '0;
            chooser_reg     <= CHOOSER_RESET;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.mode_we_local)
                local_mode_reg <= cfg_wdata;
            if (cmd.mode_we_global)
                global_mode_reg <= cfg_wdata;
            if (cmd.update)
            begin
                history_reg  <= history_next;
                chooser_reg  <= chooser_next_v;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign status.out_blocked = m_tvalid_reg && !m_tready;
    assign m_tvalid           = m_tvalid_reg;
    assign m_tdata            = m_tdata_reg;

endmodule

>>> sv/tournament_branch_predictor.sv
// Tournament branch predictor: a bimodal table indexed by the low pc bits and a
// gshare table indexed by pc xor global history, with one 2-bit chooser. Each
// input item is a resolved branch; the result item reports the predictions made
// before the tables, chooser and history are updated. An item passes through
// the registered table read, then the update and write-back through the single
// write port of each table, which waits while the output register still holds
// an untaken result; then the next item is accepted. A finished result waits in
// the output register without holding up the next item's read. After reset and
// after every mode register write, the affected tables are refilled with the
// mode midpoint by a sweep of 2^12 = 4096 entries, during which no item is accepted.
module tournament_branch_predictor
    import tbp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [S_TDATA_BITS-1:0] s_tdata,   // pc [31:0], taken [32], zero pad
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_BITS-1:0] m_tdata,   // prediction, local_guess, global_guess,
                                               // chose_global, mispredicted, zero pad
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic                    cfg_wdata
);

    tbp_cmd_t    cmd;
    tbp_status_t status;

    tbp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .status    (status),
        .cmd       (cmd)
    );

    tbp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import tbp_pkg::*;

    localparam logic MODE_TWO_BIT   = 1'b0;
    localparam logic MODE_THREE_BIT = 1'b1;
    localparam int   PHASES         = 6;
    localparam int   PHASE_ITEMS    = 285;
    localparam int   POOL_SIZE      = 12;
    localparam int   DIRECTED_ROWS  = 19;
    // table refill sweep after reset or a mode write, plus some margin
    localparam int   SWEEP_WAIT     = (1 << CLR_BITS) + 16;
    localparam int   CYCLE_LIMIT    = 400000;

    typedef struct packed {
        logic mispredicted;
        logic chose_global;
        logic global_guess;
        logic local_guess;
        logic prediction;
    } verdict_t;

    typedef struct packed {
        logic [PC_BITS-1:0] pc;
        logic               taken;
        logic               typed;
        logic [4:0]         fixed;
    } branch_row_t;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;
    logic                    cfg_we    = 1'b0;
    logic                    cfg_index = CFG_LOCAL_MODE;
    logic                    cfg_wdata = MODE_TWO_BIT;

    // predictor state
    logic [CTR_BITS-1:0]     bimodal_ctr [LOCAL_DEPTH];
    logic [CTR_BITS-1:0]     gshare_ctr [GLOBAL_DEPTH];
    logic [HISTORY_BITS-1:0] branch_hist;
    logic [1:0]              chooser_ctr;
    logic                    bimodal_mode;
    logic                    gshare_mode;

    verdict_t    pending_verdicts[$];
    branch_row_t directed_rows [DIRECTED_ROWS];
    int          mismatches  = 0;
    int          cycle_count = 0;
    int          src_idle    = 0;
    int          rcv_idle    = 0;

    tournament_branch_predictor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    function automatic logic ctr_says_taken(input logic [CTR_BITS-1:0] v, input logic mode);
        if (mode == MODE_THREE_BIT)
            return v >= 3'd4;
        return v >= 3'd2;
    endfunction

    function automatic logic [CTR_BITS-1:0] ctr_advance(input logic [CTR_BITS-1:0] v,
                                                        input logic mode,
                                                        input logic taken);
        logic [CTR_BITS-1:0] ceiling;
        ceiling = (mode == MODE_THREE_BIT) ? 3'd7 : 3'd3;
        if (taken)
        begin
            // weak not-taken jumps straight to strong side
            if (mode == MODE_THREE_BIT && v == 3'd3)
                return 3'd6;
            if (mode == MODE_TWO_BIT && v == 3'd1)
                return 3'd3;
            return (v == ceiling) ? v : v + 3'd1;
        end
        if (mode == MODE_THREE_BIT && v == 3'd4)
            return 3'd0;
        if (mode == MODE_TWO_BIT && v == 3'd2)
            return 3'd0;
        return (v == 3'd0) ? v : v - 3'd1;
    endfunction

    function automatic verdict_t resolve_branch(input logic [PC_BITS-1:0] pc,
                                                input logic taken);
        verdict_t                   r;
        logic [LOCAL_INDEX_BITS-1:0]  li;
        logic [GLOBAL_INDEX_BITS-1:0] gi;
        logic [PC_BITS-1:0]           mixed;
        logic                         local_ok;
        logic                         global_ok;
        li    = pc[LOCAL_INDEX_BITS-1:0];
        mixed = pc ^ PC_BITS'(branch_hist);
        gi    = mixed[GLOBAL_INDEX_BITS-1:0];
        r.local_guess  = ctr_says_taken(bimodal_ctr[li], bimodal_mode);
        r.global_guess = ctr_says_taken(gshare_ctr[gi], gshare_mode);
        r.chose_global = chooser_ctr[1];
        r.prediction   = r.chose_global ? r.global_guess : r.local_guess;
        r.mispredicted = r.prediction ^ taken;
        local_ok  = (r.local_guess == taken);
        global_ok = (r.global_guess == taken);
        // chooser has the same hysteresis as a two-bit counter
        if (!local_ok && global_ok)
            chooser_ctr = (chooser_ctr == 2'd1) ? 2'd3 :
                          (chooser_ctr == 2'd3) ? 2'd3 : chooser_ctr + 2'd1;
        else if (local_ok && !global_ok)
            chooser_ctr = (chooser_ctr == 2'd2) ? 2'd0 :
                          (chooser_ctr == 2'd0) ? 2'd0 : chooser_ctr - 2'd1;
        bimodal_ctr[li] = ctr_advance(bimodal_ctr[li], bimodal_mode, taken);
        gshare_ctr[gi]  = ctr_advance(gshare_ctr[gi], gshare_mode, taken);
        branch_hist     = {branch_hist[HISTORY_BITS-2:0], taken};
        return r;
    endfunction

    task automatic refill_bimodal(input logic mode);
        int i;
        bimodal_mode = mode;
        for (i = 0; i < LOCAL_DEPTH; i++)
            bimodal_ctr[i] = (mode == MODE_THREE_BIT) ? 3'd4 : 3'd2;
    endtask

    task automatic refill_gshare(input logic mode);
        int i;
        gshare_mode = mode;
        for (i = 0; i < GLOBAL_DEPTH; i++)
            gshare_ctr[i] = (mode == MODE_THREE_BIT) ? 3'd4 : 3'd2;
    endtask

    task automatic offer_branch(input logic [PC_BITS-1:0] pc, input logic taken,
                                input logic typed, input logic [4:0] fixed);
        verdict_t v;
        if ($urandom_range(99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_BITS-PC_BITS-1){1'b0}}, taken, pc};
        do @(posedge clk); while (!s_tready);
        v = resolve_branch(pc, taken);
        pending_verdicts.push_back(typed ? verdict_t'(fixed) : v);
    endtask

    task automatic write_mode(input logic idx, input logic mode);
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_LOCAL_MODE)
            refill_bimodal(mode);
        else
            refill_gshare(mode);
        repeat (SWEEP_WAIT) @(posedge clk);
    endtask

    task automatic compare_field(input string name, input logic want, input logic got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0b actual %0b", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= rcv_idle);
    end

    always @(posedge clk)
    begin
        verdict_t got;
        verdict_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = verdict_t'(m_tdata[4:0]);
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: unexpected item, expected none actual %h", $time, m_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                compare_field("prediction", want.prediction, got.prediction);
                compare_field("local_guess", want.local_guess, got.local_guess);
                compare_field("global_guess", want.global_guess, got.global_guess);
                compare_field("chose_global", want.chose_global, got.chose_global);
                compare_field("mispredicted", want.mispredicted, got.mispredicted);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tournament_branch_predictor: mismatch");
            $finish;
        end
    end

    initial
    begin
        logic [1:0]         phase_modes [PHASES];
        logic [PC_BITS-1:0] pool_pc [POOL_SIZE];
        int                 pool_bias [POOL_SIZE];
        int                 p;
        int                 n;
        int                 k;
        logic [PC_BITS-1:0] pc;
        logic               tk;

        // {gshare mode, bimodal mode} per phase
        phase_modes = '{2'b00, 2'b11, 2'b01, 2'b10, 2'b11, 2'b00};
        // first two rows hit fresh entries straight after reset
        directed_rows = '{
            '{32'h0000_0000, 1'b1, 1'b1, 5'h0F},
            '{32'hFFFF_FFFF, 1'b0, 1'b1, 5'h1F},
            '{32'h0000_0000, 1'b1, 1'b0, 5'h00},
            '{32'h8000_0000, 1'b0, 1'b0, 5'h00},
            '{32'h7FFF_FFFF, 1'b1, 1'b0, 5'h00},
            '{32'h0000_0FFF, 1'b0, 1'b0, 5'h00},
            '{32'hFFFF_F000, 1'b1, 1'b0, 5'h00},
            // one address walked through both hysteresis jumps
            '{32'h0000_0123, 1'b0, 1'b0, 5'h00},
            '{32'h0000_0123, 1'b1, 1'b0, 5'h00},
            '{32'h0000_0123, 1'b1, 1'b0, 5'h00},
            '{32'h0000_0123, 1'b0, 1'b0, 5'h00},
            '{32'h0000_0123, 1'b0, 1'b0, 5'h00},
            '{32'h0000_0123, 1'b0, 1'b0, 5'h00},
            '{32'h0000_0123, 1'b1, 1'b0, 5'h00},
            '{32'h0000_0123, 1'b1, 1'b0, 5'h00},
            '{32'h0000_0123, 1'b1, 1'b0, 5'h00},
            '{32'h0000_0123, 1'b0, 1'b0, 5'h00},
            '{32'hA5A5_A5A5, 1'b1, 1'b0, 5'h00},
            '{32'h5A5A_5A5A, 1'b0, 1'b0, 5'h00}
        };

        refill_bimodal(MODE_TWO_BIT);
        refill_gshare(MODE_TWO_BIT);
        branch_hist = '0;
        chooser_ctr = CHOOSER_RESET;

        src_idle = 28;
        rcv_idle = 75;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // items simply wait on tready during the clearing sweep
        for (n = 0; n < DIRECTED_ROWS; n++)
            offer_branch(directed_rows[n].pc, directed_rows[n].taken,
                         directed_rows[n].typed, directed_rows[n].fixed);
        s_tvalid <= 1'b0;

        for (p = 0; p < PHASES; p++)
        begin
            if (p == 2)
            begin
                src_idle = 75;
                rcv_idle = 28;
            end
            else if (p == 4)
            begin
                src_idle = 0;
                rcv_idle = 0;
            end
            write_mode(CFG_LOCAL_MODE, phase_modes[p][0]);
            write_mode(CFG_GLOBAL_MODE, phase_modes[p][1]);

            // a few hot branches with strong, weak or no bias, so entries get reused
            for (k = 0; k < POOL_SIZE; k++)
            begin
                pool_pc[k] = $urandom;
                case ($urandom_range(4))
                    0: pool_bias[k] = 0;
                    1: pool_bias[k] = 100;
                    2: pool_bias[k] = 90;
                    3: pool_bias[k] = 10;
                    default: pool_bias[k] = 50;
                endcase
            end

            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(99) < 75)
                begin
                    k  = $urandom_range(POOL_SIZE - 1);
                    pc = pool_pc[k];
                    tk = ($urandom_range(99) < pool_bias[k]);
                end
                else
                begin
                    pc = $urandom;
                    tk = 1'($urandom_range(1));
                end
                offer_branch(pc, tk, 1'b0, 5'h00);
            end
            s_tvalid <= 1'b0;
        end

        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("tournament_branch_predictor: match");
        else
            $display("tournament_branch_predictor: mismatch");
        $finish;
    end

endmodule

>>> files.f
sv/tbp_pkg.sv
sv/tbp_ctrl.sv
sv/tbp_datapath.sv
sv/tournament_branch_predictor.sv
tb/testbench.sv
